### rtl/mcc_pkg.sv
// Shared types and constants of the minimum coin change block.
`timescale 1ns / 1ps

package mcc_pkg;

  localparam int COIN_W     = 10;
  localparam int TGT_W      = 10;
  localparam int MIN_W      = 10;
  localparam int CNT_W      = 11;
  localparam int MAX_AMOUNT = 1023;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 16;

  localparam logic [CNT_W-1:0] UNREACH = {CNT_W{1'b1}};

  // register index, decoded from paddr[2]
  localparam logic REG_TARGET = 1'b0;

  typedef struct packed {
    logic load;
    logic issue;
    logic rd;
    logic res_capture;
    logic clr;
  } mcc_cmd_t;

  typedef struct packed {
    logic coin_ok;
    logic last;
    logic sweep_end;
    logic clr_done;
    logic out_free;
  } mcc_sts_t;

endpackage

### rtl/mcc_ram.sv
// Generic single-write, dual-read RAM with registered read-first outputs.
`timescale 1ns / 1ps

module mcc_ram #(
  parameter int Width = mcc_pkg::CNT_W,
  parameter int Depth = mcc_pkg::MAX_AMOUNT + 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### rtl/mcc_ctrl.sv
// Sequencer for load, table sweep, result read and table clear.
`timescale 1ns / 1ps

module mcc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  mcc_pkg::mcc_sts_t sts_i,
  output mcc_pkg::mcc_cmd_t cmd_o
);
  import mcc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_RD    = 3'd4;
  localparam logic [2:0] ST_RES   = 3'd5;
  localparam logic [2:0] ST_CLR   = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts_i.coin_ok) begin
          state_d = ST_SWEEP;
        end else if (sts_i.last) begin
          state_d = ST_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        cmd_o.issue = 1'b1;
        if (sts_i.sweep_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = sts_i.last ? ST_RD : ST_IDLE;
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_RES;
      end
      ST_RES: begin
        cmd_o.rd = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.res_capture = 1'b1;
          state_d           = ST_CLR;
        end
      end
      ST_CLR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // reset lands in the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/mcc_datapath.sv
// Best-count table, sweep pipeline with write bypass, and result register.
`timescale 1ns / 1ps

module mcc_datapath #(
  parameter int MaxAmount = mcc_pkg::MAX_AMOUNT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mcc_pkg::mcc_cmd_t         cmd_i,
  output mcc_pkg::mcc_sts_t         sts_o,
  input  logic [mcc_pkg::COIN_W-1:0] coin_i,
  input  logic                      last_i,
  input  logic [mcc_pkg::TGT_W-1:0]  target_i,
  input  logic                      m_ready_i,
  output logic                      m_valid_o,
  output logic [mcc_pkg::MIN_W-1:0]  min_o,
  output logic                      reach_o
);
  import mcc_pkg::*;

  localparam int Depth = MaxAmount + 1;
  localparam int AW    = $clog2(Depth);

  logic [COIN_W-1:0] coin_q;
  logic [TGT_W-1:0]  tgt_q;
  logic              last_q;
  logic [AW-1:0]     ptr_q;

  logic              c_vld_q;
  logic [AW-1:0]     c_lo_q, c_hi_q;
  logic              w_vld_q;
  logic [AW-1:0]     w_addr_q;
  logic [CNT_W-1:0]  w_data_q;

  logic [AW-1:0]     clr_q;
  logic              res_vld_q;
  logic [MIN_W-1:0]  min_q;
  logic              reach_q;

  logic              in_range;
  logic [AW-1:0]     tgt_addr, lo_addr, raddr_a;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CNT_W-1:0]  ram_wdata, clr_val;
  logic [CNT_W-1:0]  rd_a, rd_b, lo_val, plus1, upd;
  logic              res_reach;

  assign in_range = (32'(tgt_q) <= 32'(MaxAmount));
  assign tgt_addr = AW'(tgt_q);
  assign lo_addr  = ptr_q - AW'(coin_q);
  assign raddr_a  = cmd_i.rd ? tgt_addr : lo_addr;

  // the write of the previous cycle is not seen by a read-first RAM
  assign lo_val = (w_vld_q && (w_addr_q == c_lo_q)) ? w_data_q : rd_a;
  assign plus1  = lo_val + CNT_W'(1);
  assign upd    = ((lo_val != UNREACH) && (plus1 < rd_b)) ? plus1 : rd_b;

  assign clr_val   = (clr_q == '0) ? '0 : UNREACH;
  assign ram_we    = cmd_i.clr | c_vld_q;
  assign ram_waddr = cmd_i.clr ? clr_q : c_hi_q;
  assign ram_wdata = cmd_i.clr ? clr_val : upd;

  mcc_ram #(
    .Width(CNT_W),
    .Depth(Depth)
  ) u_table (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(ptr_q),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  assign res_reach = in_range && (rd_a != UNREACH);

  always_comb begin
    sts_o           = '0;
    sts_o.coin_ok   = (coin_q != '0) && (coin_q <= tgt_q) && in_range;
    sts_o.last      = last_q;
    sts_o.sweep_end = (ptr_q == tgt_addr);
    sts_o.clr_done  = (clr_q == AW'(MaxAmount));
    sts_o.out_free  = !res_vld_q || m_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      coin_q <= coin_i;
      tgt_q  <= target_i;
      last_q <= last_i;
      ptr_q  <= AW'(coin_i);
    end else if (cmd_i.issue) begin
      ptr_q <= ptr_q + AW'(1);
    end
    c_lo_q   <= lo_addr;
    c_hi_q   <= ptr_q;
    w_addr_q <= c_hi_q;
    w_data_q <= upd;
    if (cmd_i.res_capture) begin
      reach_q <= res_reach;
      min_q   <= res_reach ? rd_a[MIN_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q   <= 1'b0;
      w_vld_q   <= 1'b0;
      clr_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      c_vld_q <= cmd_i.issue;
      w_vld_q <= c_vld_q;
      if (cmd_i.clr) begin
        clr_q <= sts_o.clr_done ? '0 : clr_q + AW'(1);
      end
      if (cmd_i.res_capture) begin
        res_vld_q <= 1'b1;
      end else if (m_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = res_vld_q;
  assign min_o     = min_q;
  assign reach_o   = reach_q;

  a_no_clear_during_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr |-> !c_vld_q && !cmd_i.issue)
    else $error("table clear overlaps a sweep");

  a_capture_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_capture |-> (!res_vld_q || m_ready_i))
    else $error("result captured over a pending item");

  a_sweep_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> (ptr_q <= tgt_addr) && in_range)
    else $error("sweep pointer beyond target");

endmodule

### rtl/min_coin_change_dp.sv
// Sequence: a coin item is loaded, then swept over the table entries from coin up to
// target; an ignored coin is only loaded. The last coin adds a result read, then a
// table clearing pass during which no item is accepted.
// Throughput: one table entry per cycle, set by the table RAM's single write port.
// Reset: target_amount is 0 and a clearing pass over every table entry runs first.
`timescale 1ns / 1ps

module min_coin_change_dp #(
  parameter int MaxAmount = mcc_pkg::MAX_AMOUNT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // s_axis_tdata_i: coin_value [9:0]
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [mcc_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  input  logic                            s_axis_tlast_i,
  // m_axis_tdata_o: min_coins [9:0]
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [mcc_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // m_axis_tuser_o: reachable [0]
  output logic                            m_axis_tuser_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mcc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [mcc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [mcc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import mcc_pkg::*;

  logic [TGT_W-1:0] target_q;
  logic             reg_hit;
  mcc_cmd_t         cmd;
  mcc_sts_t         sts;
  logic [MIN_W-1:0] min_coins;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_TARGET);
  assign prdata  = reg_hit ? APB_DATA_W'(target_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      target_q <= pwdata[TGT_W-1:0];
    end
  end

  mcc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid_i),
    .s_ready_o(s_axis_tready_o),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  mcc_datapath #(
    .MaxAmount(MaxAmount)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .coin_i   (s_axis_tdata_i[COIN_W-1:0]),
    .last_i   (s_axis_tlast_i),
    .target_i (target_q),
    .m_ready_i(m_axis_tready_i),
    .m_valid_o(m_axis_tvalid_o),
    .min_o    (min_coins),
    .reach_o  (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = M_TDATA_W'(min_coins);

endmodule
